// File: hdl/rc_channel_motor_mixer_core_assert.svh
// Assertion macros for the RC motor mixer checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef RC_CHANNEL_MOTOR_MIXER_CORE_ASSERT_SVH
`define RC_CHANNEL_MOTOR_MIXER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RCMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcmm_pkg.sv
// Shared constants, types and register codes for the RC motor mixer.
// No dependencies; imported by every module of the block.
package rcmm_pkg;

  localparam int FRACTION_BITS = 15;
  localparam int CHANNEL_BITS  = 11;

  localparam int STICK_W    = 11;
  localparam int CH_W       = 11;
  localparam int PERIOD_W   = 12;
  localparam int DZ_W       = 15;
  localparam int ROW_W      = 8;
  localparam int MIDI_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int N_STICKS  = 4;
  localparam int N_MOTORS  = 4;
  localparam int N_LANES   = 6;
  localparam int STICK_THR = 2;
  localparam int STICK_RUD = 3;
  localparam int LANE_THR_MIDI = 4;
  localparam int LANE_RUD_MIDI = 5;

  // quotient of (d << (F+1)) / span is at most 2^(F+1)
  localparam int Q_W   = FRACTION_BITS + 2;
  localparam int N_W   = CH_W + Q_W;
  localparam int S_W   = FRACTION_BITS + 2;
  localparam int D_W   = FRACTION_BITS + 4;
  localparam int M_W   = FRACTION_BITS + 3;
  localparam int PROD_W = M_W + PERIOD_W;
  localparam int LVL_W  = PROD_W - FRACTION_BITS;

  localparam int DIV_STEPS     = Q_W;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int MIX_STAGES    = 5;
  localparam int LATENCY       = 2 + DIV_STAGES + MIX_STAGES;

  localparam logic [CH_W-1:0] CH_MASK =
    CH_W'((64'd1 << ((CHANNEL_BITS < CH_W) ? CHANNEL_BITS : CH_W)) - 64'd1);

  localparam logic [CH_W-1:0]     RST_CHANNEL_MIN = CH_W'(989);
  localparam logic [CH_W-1:0]     RST_CHANNEL_MAX = CH_W'(2011);
  localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD  = PERIOD_W'(1000);
  localparam logic [DZ_W-1:0]     RST_DEAD_ZONE   = DZ_W'(6554);
  localparam logic [ROW_W-1:0]    RST_ROW_AILERON  = ROW_W'(221);
  localparam logic [ROW_W-1:0]    RST_ROW_ELEVATOR = ROW_W'(85);
  localparam logic [ROW_W-1:0]    RST_ROW_THROTTLE = ROW_W'(0);
  localparam logic [ROW_W-1:0]    RST_ROW_RUDDER   = ROW_W'(125);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_MIN  = 3'd0,
    REG_CHANNEL_MAX  = 3'd1,
    REG_PWM_PERIOD   = 3'd2,
    REG_DEAD_ZONE    = 3'd3,
    REG_ROW_AILERON  = 3'd4,
    REG_ROW_ELEVATOR = 3'd5,
    REG_ROW_THROTTLE = 3'd6,
    REG_ROW_RUDDER   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COEF_ZERO   = 2'b00,
    COEF_PLUS   = 2'b01,
    COEF_UNUSED = 2'b10,
    COEF_MINUS  = 2'b11
  } coef_code_t;

  typedef struct packed {
    logic [CH_W-1:0]                    channel_min;
    logic [CH_W-1:0]                    channel_max;
    logic [PERIOD_W-1:0]                pwm_period;
    logic [DZ_W-1:0]                    dead_zone;
    logic [N_STICKS-1:0][ROW_W-1:0]     mix_rows;
  } cfg_t;

  // one division lane: running remainder and numerator/quotient shift word
  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [Q_W-1:0]  word;
  } lane_t;

endpackage

// File: hdl/rcmm_cfg.sv
// Configuration register file of the RC motor mixer.
// Depends on rcmm_pkg for the register codes, reset values and cfg_t.
module rcmm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rcmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rcmm_pkg::cfg_t                  cfg
);
  import rcmm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_MIN:  cfg_nxt.channel_min = cfg_wdata[CH_W-1:0] & CH_MASK;
        REG_CHANNEL_MAX:  cfg_nxt.channel_max = cfg_wdata[CH_W-1:0] & CH_MASK;
        REG_PWM_PERIOD:   cfg_nxt.pwm_period  = cfg_wdata[PERIOD_W-1:0];
        REG_DEAD_ZONE:    cfg_nxt.dead_zone   = cfg_wdata[DZ_W-1:0];
        REG_ROW_AILERON:  cfg_nxt.mix_rows[0] = cfg_wdata[ROW_W-1:0];
        REG_ROW_ELEVATOR: cfg_nxt.mix_rows[1] = cfg_wdata[ROW_W-1:0];
        REG_ROW_THROTTLE: cfg_nxt.mix_rows[2] = cfg_wdata[ROW_W-1:0];
        REG_ROW_RUDDER:   cfg_nxt.mix_rows[3] = cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_min <= RST_CHANNEL_MIN;
      cfg_r.channel_max <= RST_CHANNEL_MAX;
      cfg_r.pwm_period  <= RST_PWM_PERIOD;
      cfg_r.dead_zone   <= RST_DEAD_ZONE;
      cfg_r.mix_rows    <= {RST_ROW_RUDDER, RST_ROW_THROTTLE,
                            RST_ROW_ELEVATOR, RST_ROW_AILERON};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/rcmm_front.sv
// Front end: clamps each stick to the channel range and loads the divider lanes.
// Depends on rcmm_pkg; feeds rcmm_div.
module rcmm_front (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_vld,
  input  logic [rcmm_pkg::N_STICKS-1:0][rcmm_pkg::STICK_W-1:0]  sticks,
  input  rcmm_pkg::cfg_t                                        cfg,
  output logic                                                  out_vld,
  output rcmm_pkg::lane_t [rcmm_pkg::N_LANES-1:0]               lanes
);
  import rcmm_pkg::*;

  localparam int SH = FRACTION_BITS + 1;

  logic                           vld1_r, vld1_nxt;
  logic [N_STICKS-1:0][CH_W-1:0]  d_r, d_nxt;
  logic                           vld2_r, vld2_nxt;
  lane_t [N_LANES-1:0]            lane_r, lane_nxt;

  // stage 1: clamp to [min, max] and take the offset from min
  always_comb begin : p_clamp
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] cl;
    c  = '0;
    cl = '0;
    vld1_nxt = in_vld;
    for (int s = 0; s < N_STICKS; s++) begin
      c = sticks[s][CH_W-1:0] & CH_MASK;
      if (c < cfg.channel_min) begin
        cl = cfg.channel_min;
      end else if (c > cfg.channel_max) begin
        cl = cfg.channel_max;
      end else begin
        cl = c;
      end
      d_nxt[s] = cl - cfg.channel_min;
    end
  end

  // stage 2: numerators; the high part seeds the remainder, the rest is shifted in
  always_comb begin : p_load
    logic [N_W-1:0] num;
    num = '0;
    vld2_nxt = vld1_r;
    for (int s = 0; s < N_STICKS; s++) begin
      num = N_W'({d_r[s], {SH{1'b0}}});
      lane_nxt[s].rem  = num[N_W-1:Q_W];
      lane_nxt[s].word = num[Q_W-1:0];
    end
    // d * 127 as (d << 7) - d
    num = N_W'({d_r[STICK_THR], {MIDI_W{1'b0}}}) - N_W'(d_r[STICK_THR]);
    lane_nxt[LANE_THR_MIDI].rem  = num[N_W-1:Q_W];
    lane_nxt[LANE_THR_MIDI].word = num[Q_W-1:0];
    num = N_W'({d_r[STICK_RUD], {MIDI_W{1'b0}}}) - N_W'(d_r[STICK_RUD]);
    lane_nxt[LANE_RUD_MIDI].rem  = num[N_W-1:Q_W];
    lane_nxt[LANE_RUD_MIDI].word = num[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
    end
    d_r    <= d_nxt;
    lane_r <= lane_nxt;
  end

  assign out_vld = vld2_r;
  assign lanes   = lane_r;

endmodule

// File: hdl/rcmm_div.sv
// Pipelined restoring divider: six lanes share the span divisor,
// DIV_PER_STAGE quotient bits per stage. Depends on rcmm_pkg.
module rcmm_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_vld,
  input  logic [rcmm_pkg::CH_W-1:0]                          span,
  input  rcmm_pkg::lane_t [rcmm_pkg::N_LANES-1:0]            lanes_in,
  output logic                                               out_vld,
  output logic [rcmm_pkg::N_LANES-1:0][rcmm_pkg::Q_W-1:0]    quo
);
  import rcmm_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES-1:0] vld_nxt;
  lane_t [N_LANES-1:0]   lane_r   [DIV_STAGES];
  lane_t [N_LANES-1:0]   lane_nxt [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    lane_t [N_LANES-1:0] src;
    lane_t [N_LANES-1:0] res;

    if (g == 0) begin : g_first
      assign src        = lanes_in;
      assign vld_nxt[g] = in_vld;
    end else begin : g_rest
      assign src        = lane_r[g-1];
      assign vld_nxt[g] = vld_r[g-1];
    end

    always_comb begin : p_step
      logic [CH_W:0] r_pre;
      lane_t         cur;
      r_pre = '0;
      for (int l = 0; l < N_LANES; l++) begin
        cur = src[l];
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
          if (g * DIV_PER_STAGE + k < DIV_STEPS) begin
            r_pre = {cur.rem, cur.word[Q_W-1]};
            if (r_pre >= {1'b0, span}) begin
              cur.rem  = CH_W'(r_pre - {1'b0, span});
              cur.word = {cur.word[Q_W-2:0], 1'b1};
            end else begin
              cur.rem  = r_pre[CH_W-1:0];
              cur.word = {cur.word[Q_W-2:0], 1'b0};
            end
          end
        end
        res[l] = cur;
      end
    end

    assign lane_nxt[g] = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    lane_r <= lane_nxt;
  end

  assign out_vld = vld_r[DIV_STAGES-1];

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      quo[l] = lane_r[DIV_STAGES-1][l].word;
    end
  end

endmodule

// File: hdl/rcmm_mix.sv
// Back end: stick values, 4x4 mix, dead zone, PWM scaling and output registers.
// Depends on rcmm_pkg; takes the quotients from rcmm_div.
module rcmm_mix (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_vld,
  input  logic [rcmm_pkg::N_LANES-1:0][rcmm_pkg::Q_W-1:0]        quo,
  input  rcmm_pkg::cfg_t                                         cfg,
  output logic                                                   out_vld,
  output logic [rcmm_pkg::MIDI_W-1:0]                            mod_wheel,
  output logic [rcmm_pkg::MIDI_W-1:0]                            foot_pedal,
  output logic [rcmm_pkg::N_MOTORS-1:0][rcmm_pkg::PERIOD_W-1:0]  fwd,
  output logic [rcmm_pkg::N_MOTORS-1:0][rcmm_pkg::PERIOD_W-1:0]  rev
);
  import rcmm_pkg::*;

  localparam logic [Q_W:0] S_OFFSET = (Q_W+1)'(1) << FRACTION_BITS;

  logic [MIX_STAGES-1:0] vld_r, vld_nxt;
  logic [1:0][MIDI_W-1:0] midi_r [MIX_STAGES-1];
  logic [1:0][MIDI_W-1:0] midi_nxt;

  logic signed [S_W-1:0] s_r     [N_STICKS];
  logic signed [S_W-1:0] s_nxt   [N_STICKS];
  logic signed [D_W-1:0] drv_r   [N_MOTORS];
  logic signed [D_W-1:0] drv_nxt [N_MOTORS];
  logic [M_W-1:0]        mag_r   [N_MOTORS];
  logic [M_W-1:0]        mag_nxt [N_MOTORS];
  logic [N_MOTORS-1:0]   neg3_r, neg3_nxt, on3_r, on3_nxt;
  logic [PROD_W-1:0]     prod_r  [N_MOTORS];
  logic [PROD_W-1:0]     prod_nxt[N_MOTORS];
  logic [N_MOTORS-1:0]   neg4_r, on4_r;
  logic [N_MOTORS-1:0][PERIOD_W-1:0] fwd_r, fwd_nxt, rev_r, rev_nxt;
  logic [MIDI_W-1:0]     mod_r, mod_nxt, ped_r, ped_nxt;
  logic                  empty;

  assign empty = (cfg.channel_max <= cfg.channel_min);

  assign vld_nxt = {vld_r[MIX_STAGES-2:0], in_vld};

  // stage 1: signed stick value S = q - 1.0, MIDI value is the low quotient bits
  always_comb begin : p_sval
    logic [Q_W:0] diff;
    diff = '0;
    for (int s = 0; s < N_STICKS; s++) begin
      diff     = {1'b0, quo[s]} - S_OFFSET;
      s_nxt[s] = S_W'(diff);
    end
    midi_nxt[0] = quo[LANE_THR_MIDI][MIDI_W-1:0];
    midi_nxt[1] = quo[LANE_RUD_MIDI][MIDI_W-1:0];
  end

  // stage 2: drive of each motor, sum of +/- stick values
  always_comb begin : p_mix
    logic signed [D_W-1:0] acc;
    coef_code_t            code;
    acc  = '0;
    code = COEF_ZERO;
    for (int m = 0; m < N_MOTORS; m++) begin
      acc = '0;
      for (int s = 0; s < N_STICKS; s++) begin
        code = coef_code_t'(cfg.mix_rows[s][2*m +: 2]);
        case (code)
          COEF_PLUS:  acc = acc + D_W'(s_r[s]);
          COEF_MINUS: acc = acc - D_W'(s_r[s]);
          default: ;
        endcase
      end
      drv_nxt[m] = acc;
    end
  end

  // stage 3: magnitude, direction, dead zone
  always_comb begin : p_mag
    logic [D_W-1:0] absd;
    absd = '0;
    for (int m = 0; m < N_MOTORS; m++) begin
      absd = drv_r[m][D_W-1] ? D_W'(-drv_r[m]) : D_W'(drv_r[m]);
      mag_nxt[m]  = absd[M_W-1:0];
      neg3_nxt[m] = drv_r[m][D_W-1];
      on3_nxt[m]  = {{DZ_W{1'b0}}, absd[M_W-1:0]} > {{M_W{1'b0}}, cfg.dead_zone};
    end
  end

  // stage 4: magnitude times period
  always_comb begin
    for (int m = 0; m < N_MOTORS; m++) begin
      prod_nxt[m] = PROD_W'(mag_r[m]) * PROD_W'(cfg.pwm_period);
    end
  end

  // stage 5: drop fraction, saturate at the period, steer to one side
  always_comb begin : p_level
    logic [LVL_W-1:0]    lvl;
    logic [PERIOD_W-1:0] sat;
    lvl = '0;
    sat = '0;
    for (int m = 0; m < N_MOTORS; m++) begin
      lvl = prod_r[m][PROD_W-1:FRACTION_BITS];
      sat = (lvl > LVL_W'(cfg.pwm_period)) ? cfg.pwm_period : lvl[PERIOD_W-1:0];
      fwd_nxt[m] = (on4_r[m] && !neg4_r[m] && !empty) ? sat : '0;
      rev_nxt[m] = (on4_r[m] &&  neg4_r[m] && !empty) ? sat : '0;
    end
    mod_nxt = empty ? '0 : midi_r[MIX_STAGES-2][0];
    ped_nxt = empty ? '0 : midi_r[MIX_STAGES-2][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    midi_r[0] <= midi_nxt;
    for (int i = 1; i < MIX_STAGES - 1; i++) begin
      midi_r[i] <= midi_r[i-1];
    end
    s_r    <= s_nxt;
    drv_r  <= drv_nxt;
    mag_r  <= mag_nxt;
    neg3_r <= neg3_nxt;
    on3_r  <= on3_nxt;
    prod_r <= prod_nxt;
    neg4_r <= neg3_r;
    on4_r  <= on3_r;
    fwd_r  <= fwd_nxt;
    rev_r  <= rev_nxt;
    mod_r  <= mod_nxt;
    ped_r  <= ped_nxt;
  end

  assign out_vld    = vld_r[MIX_STAGES-1];
  assign mod_wheel  = mod_r;
  assign foot_pedal = ped_r;
  assign fwd        = fwd_r;
  assign rev        = rev_r;

endmodule

// File: hdl/rc_channel_motor_mixer_core.sv
// Top level of the RC stick-to-motor mixer.
// Depends on rcmm_pkg, rcmm_cfg, rcmm_front, rcmm_div and rcmm_mix.
//
// One request per clock: busy stays low and a request is taken on every cycle
// that start is high. Each request comes back on the out_ ports, marked by
// out_valid for a single cycle; the receiver must take it then, as the block
// cannot stall. The request path is two front stages (clamp, divider load),
// five divider stages (17 quotient bits, four per stage, shared by the four
// sticks and the two MIDI lanes) and five back-end stages (stick value, mix,
// dead zone, multiply by period, output register).
// Write configuration only while no request is in flight.
module rc_channel_motor_mixer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rcmm_pkg::STICK_W-1:0]     in_stick_aileron,
  input  logic [rcmm_pkg::STICK_W-1:0]     in_stick_elevator,
  input  logic [rcmm_pkg::STICK_W-1:0]     in_stick_throttle,
  input  logic [rcmm_pkg::STICK_W-1:0]     in_stick_rudder,
  output logic                             out_valid,
  output logic [rcmm_pkg::MIDI_W-1:0]      out_mod_wheel_value,
  output logic [rcmm_pkg::MIDI_W-1:0]      out_foot_pedal_value,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor0_forward,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor0_reverse,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor1_forward,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor1_reverse,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor2_forward,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor2_reverse,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor3_forward,
  output logic [rcmm_pkg::PERIOD_W-1:0]    out_motor3_reverse,
  input  logic                             cfg_we,
  input  logic [rcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcmm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rcmm_pkg::*;

  cfg_t                             cfg;
  logic [N_STICKS-1:0][STICK_W-1:0] sticks;
  logic                             front_vld;
  lane_t [N_LANES-1:0]              lanes;
  logic                             div_vld;
  logic [N_LANES-1:0][Q_W-1:0]      quo;
  logic [CH_W-1:0]                  span;
  logic [N_MOTORS-1:0][PERIOD_W-1:0] fwd;
  logic [N_MOTORS-1:0][PERIOD_W-1:0] rev;

  // fully pipelined, never refuses a request
  assign busy   = 1'b0;
  assign sticks = {in_stick_rudder, in_stick_throttle, in_stick_elevator, in_stick_aileron};
  assign span   = cfg.channel_max - cfg.channel_min;

  rcmm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcmm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .sticks  (sticks),
    .cfg     (cfg),
    .out_vld (front_vld),
    .lanes   (lanes)
  );

  rcmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .span     (span),
    .lanes_in (lanes),
    .out_vld  (div_vld),
    .quo      (quo)
  );

  rcmm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (div_vld),
    .quo        (quo),
    .cfg        (cfg),
    .out_vld    (out_valid),
    .mod_wheel  (out_mod_wheel_value),
    .foot_pedal (out_foot_pedal_value),
    .fwd        (fwd),
    .rev        (rev)
  );

  assign out_motor0_forward = fwd[0];
  assign out_motor0_reverse = rev[0];
  assign out_motor1_forward = fwd[1];
  assign out_motor1_reverse = rev[1];
  assign out_motor2_forward = fwd[2];
  assign out_motor2_reverse = rev[2];
  assign out_motor3_forward = fwd[3];
  assign out_motor3_reverse = rev[3];

endmodule

// File: hdl/rcmm_checker.sv
// Port-level checker for the RC motor mixer, bound to the top level.
// Depends on rcmm_pkg and rc_channel_motor_mixer_core_assert.svh.
`include "rc_channel_motor_mixer_core_assert.svh"

module rcmm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor0_forward,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor0_reverse,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor1_forward,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor1_reverse,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor2_forward,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor2_reverse,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor3_forward,
  input logic [rcmm_pkg::PERIOD_W-1:0]    out_motor3_reverse
);
  import rcmm_pkg::*;

  logic both_ways;

  assign both_ways = (out_motor0_forward != '0 && out_motor0_reverse != '0) ||
                     (out_motor1_forward != '0 && out_motor1_reverse != '0) ||
                     (out_motor2_forward != '0 && out_motor2_reverse != '0) ||
                     (out_motor3_forward != '0 && out_motor3_reverse != '0);

  // every result traces back to an accepted request
  `RCMM_ASSERT_NOW(a_result_has_request, out_valid, $past(start && !busy, LATENCY), "result without a matching request")

  // a motor is driven in one direction at most
  `RCMM_ASSERT_NOW(a_one_direction, out_valid, !both_ways, "motor driven both ways")

  // the pipeline never holds off a request
  `RCMM_ASSERT_NEXT(a_never_busy, start, !busy, "busy raised")

endmodule

bind rc_channel_motor_mixer_core rcmm_checker u_rcmm_checker (.*);

// File: tb/sv/tb_rc_channel_motor_mixer_core.sv
// Testbench for rc_channel_motor_mixer_core: stick clamp/scale, 4x4 mix, dead zone,
// PWM levels and MIDI values checked against a behavioral predictor per request.
// Depends on rcmm_pkg and the mixer RTL only.
module tb_rc_channel_motor_mixer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rcmm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES = 13;

  typedef struct packed {
    logic [MIDI_W-1:0]                      mod_wheel;
    logic [MIDI_W-1:0]                      foot_pedal;
    logic [N_MOTORS-1:0][PERIOD_W-1:0]      fwd;
    logic [N_MOTORS-1:0][PERIOD_W-1:0]      rev;
  } mix_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [STICK_W-1:0]      in_stick_aileron;
  logic [STICK_W-1:0]      in_stick_elevator;
  logic [STICK_W-1:0]      in_stick_throttle;
  logic [STICK_W-1:0]      in_stick_rudder;
  logic                    out_valid;
  logic [MIDI_W-1:0]       out_mod_wheel_value;
  logic [MIDI_W-1:0]       out_foot_pedal_value;
  logic [PERIOD_W-1:0]     out_motor0_forward;
  logic [PERIOD_W-1:0]     out_motor0_reverse;
  logic [PERIOD_W-1:0]     out_motor1_forward;
  logic [PERIOD_W-1:0]     out_motor1_reverse;
  logic [PERIOD_W-1:0]     out_motor2_forward;
  logic [PERIOD_W-1:0]     out_motor2_reverse;
  logic [PERIOD_W-1:0]     out_motor3_forward;
  logic [PERIOD_W-1:0]     out_motor3_reverse;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  cfg_t        shadow_cfg;
  mix_result_t expected_mix[$];
  bit          idle_en;
  int          error_count;
  int          requests_sent;
  int          results_checked;
  int          empty_range_requests;
  int          saturated_requests;
  int          settings_applied;

  rc_channel_motor_mixer_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_stick_aileron     (in_stick_aileron),
    .in_stick_elevator    (in_stick_elevator),
    .in_stick_throttle    (in_stick_throttle),
    .in_stick_rudder      (in_stick_rudder),
    .out_valid            (out_valid),
    .out_mod_wheel_value  (out_mod_wheel_value),
    .out_foot_pedal_value (out_foot_pedal_value),
    .out_motor0_forward   (out_motor0_forward),
    .out_motor0_reverse   (out_motor0_reverse),
    .out_motor1_forward   (out_motor1_forward),
    .out_motor1_reverse   (out_motor1_reverse),
    .out_motor2_forward   (out_motor2_forward),
    .out_motor2_reverse   (out_motor2_reverse),
    .out_motor3_forward   (out_motor3_forward),
    .out_motor3_reverse   (out_motor3_reverse),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected motor levels and MIDI values for one request under shadow_cfg.
  function automatic mix_result_t predict_mix(input logic [STICK_W-1:0] ail,
                                              input logic [STICK_W-1:0] ele,
                                              input logic [STICK_W-1:0] thr,
                                              input logic [STICK_W-1:0] rud);
    logic [STICK_W-1:0] sticks [N_STICKS];
    longint             drive [N_MOTORS];
    longint             lo, hi, span, c, stick_val, mag, level, period;
    coef_code_t         code;
    mix_result_t        res;
    res = '0;
    lo = longint'(shadow_cfg.channel_min);
    hi = longint'(shadow_cfg.channel_max);
    period = longint'(shadow_cfg.pwm_period);
    if (hi <= lo) return res;
    span = hi - lo;
    sticks[0] = ail;
    sticks[1] = ele;
    sticks[2] = thr;
    sticks[3] = rud;
    for (int m = 0; m < N_MOTORS; m++) drive[m] = 0;
    for (int s = 0; s < N_STICKS; s++) begin
      c = longint'(sticks[s] & CH_MASK);
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      if (s == STICK_THR) res.mod_wheel = MIDI_W'(((c - lo) * 127) / span);
      if (s == STICK_RUD) res.foot_pedal = MIDI_W'(((c - lo) * 127) / span);
      // signed Q value in [-1, +1]
      stick_val = ((c - lo) << (FRACTION_BITS + 1)) / span - (longint'(1) << FRACTION_BITS);
      for (int m = 0; m < N_MOTORS; m++) begin
        code = coef_code_t'(shadow_cfg.mix_rows[s][2*m +: 2]);
        case (code)
          COEF_PLUS:  drive[m] += stick_val;
          COEF_MINUS: drive[m] -= stick_val;
          default: ;
        endcase
      end
    end
    for (int m = 0; m < N_MOTORS; m++) begin
      mag = (drive[m] < 0) ? -drive[m] : drive[m];
      if (mag > longint'(shadow_cfg.dead_zone)) begin
        level = (mag * period) >> FRACTION_BITS;
        if (level > period) level = period;
        if (drive[m] > 0) res.fwd[m] = PERIOD_W'(level);
        else res.rev[m] = PERIOD_W'(level);
      end
    end
    return res;
  endfunction

  function automatic void store_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHANNEL_MIN: shadow_cfg.channel_min = data[CH_W-1:0] & CH_MASK;
      REG_CHANNEL_MAX: shadow_cfg.channel_max = data[CH_W-1:0] & CH_MASK;
      REG_PWM_PERIOD:  shadow_cfg.pwm_period = data[PERIOD_W-1:0];
      REG_DEAD_ZONE:   shadow_cfg.dead_zone = data[DZ_W-1:0];
      default:         shadow_cfg.mix_rows[int'(idx) - int'(REG_ROW_AILERON)] = data[ROW_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  // Result checker: every strobe must match the oldest outstanding request.
  always @(posedge clk) begin : check_results
    mix_result_t seen;
    mix_result_t want;
    if (rst_n && out_valid) begin
      seen.mod_wheel  = out_mod_wheel_value;
      seen.foot_pedal = out_foot_pedal_value;
      seen.fwd = {out_motor3_forward, out_motor2_forward, out_motor1_forward, out_motor0_forward};
      seen.rev = {out_motor3_reverse, out_motor2_reverse, out_motor1_reverse, out_motor0_reverse};
      if (expected_mix.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_mix.pop_front();
        check_field("mod_wheel_value", int'(seen.mod_wheel), int'(want.mod_wheel));
        check_field("foot_pedal_value", int'(seen.foot_pedal), int'(want.foot_pedal));
        for (int m = 0; m < N_MOTORS; m++) begin
          check_field($sformatf("motor%0d_forward", m), int'(seen.fwd[m]), int'(want.fwd[m]));
          check_field($sformatf("motor%0d_reverse", m), int'(seen.rev[m]), int'(want.rev[m]));
        end
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("rc_channel_motor_mixer_core test failed");
    $finish;
  end

  task automatic send_sticks(input logic [STICK_W-1:0] ail, input logic [STICK_W-1:0] ele,
                             input logic [STICK_W-1:0] thr, input logic [STICK_W-1:0] rud);
    mix_result_t res;
    // idle cycles carry noise on the stick ports
    while (idle_en && $urandom_range(0, 99) < 27) begin
      @(negedge clk);
      start <= 1'b0;
      in_stick_aileron  <= STICK_W'($urandom);
      in_stick_elevator <= STICK_W'($urandom);
      in_stick_throttle <= STICK_W'($urandom);
      in_stick_rudder   <= STICK_W'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    start             <= 1'b1;
    in_stick_aileron  <= ail;
    in_stick_elevator <= ele;
    in_stick_throttle <= thr;
    in_stick_rudder   <= rud;
    do @(posedge clk); while (busy);
    res = predict_mix(ail, ele, thr, rud);
    expected_mix.push_back(res);
    requests_sent++;
    if (shadow_cfg.channel_max <= shadow_cfg.channel_min) empty_range_requests++;
    for (int m = 0; m < N_MOTORS; m++)
      if (shadow_cfg.pwm_period != 0 &&
          (res.fwd[m] == shadow_cfg.pwm_period || res.rev[m] == shadow_cfg.pwm_period)) begin
        saturated_requests++;
        break;
      end
  endtask

  task automatic drain_requests;
    @(negedge clk);
    start <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value, input bit junk);
    logic [CFG_DATA_W-1:0] data;
    int                    width;
    case (idx)
      REG_CHANNEL_MIN, REG_CHANNEL_MAX: width = CH_W;
      REG_PWM_PERIOD:                   width = PERIOD_W;
      REG_DEAD_ZONE:                    width = DZ_W;
      default:                          width = ROW_W;
    endcase
    data = CFG_DATA_W'(value);
    // unused upper bits of the write data must be ignored
    if (junk && $urandom_range(0, 3) == 0) data = data | (CFG_DATA_W'($urandom) << width);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    store_setting(idx, data);
  endtask

  task automatic apply_settings(input int lo, input int hi, input int period, input int dz,
                                input int row_a, input int row_e, input int row_t,
                                input int row_r, input bit junk);
    drain_requests();
    write_reg(REG_CHANNEL_MIN, lo, junk);
    write_reg(REG_CHANNEL_MAX, hi, junk);
    write_reg(REG_PWM_PERIOD, period, junk);
    write_reg(REG_DEAD_ZONE, dz, junk);
    write_reg(REG_ROW_AILERON, row_a, junk);
    write_reg(REG_ROW_ELEVATOR, row_e, junk);
    write_reg(REG_ROW_THROTTLE, row_t, junk);
    write_reg(REG_ROW_RUDDER, row_r, junk);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [STICK_W-1:0] pick_stick();
    int lo;
    int hi;
    lo = int'(shadow_cfg.channel_min);
    hi = int'(shadow_cfg.channel_max);
    case ($urandom_range(0, 9))
      0: return STICK_W'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return '1;
          2: return STICK_W'(lo);
          3: return STICK_W'(hi);
          4: return STICK_W'(lo - 1);
          default: return STICK_W'(hi + 1);
        endcase
      end
      default: begin
        if (hi > lo) return STICK_W'($urandom_range(lo, hi));
        return STICK_W'($urandom);
      end
    endcase
  endfunction

  task automatic randomize_settings;
    int lo, hi, period, dz;
    case ($urandom_range(0, 9))
      0: begin lo = 0; hi = 2047; end
      1: begin lo = $urandom_range(0, 2047); hi = $urandom_range(0, lo); end
      2: begin lo = $urandom_range(0, 2039); hi = lo + $urandom_range(1, 8); end
      3: begin lo = 989; hi = 2011; end
      default: begin lo = $urandom_range(0, 1800); hi = $urandom_range(lo + 50, 2047); end
    endcase
    case ($urandom_range(0, 9))
      0: period = 0;
      1: period = 4095;
      2: period = 1;
      default: period = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(0, 9))
      0: dz = 0;
      1: dz = 32767;
      2: dz = $urandom_range(0, 32767);
      default: dz = $urandom_range(0, 12000);
    endcase
    apply_settings(lo, hi, period, dz, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
  endtask

  // Reset register values, sticks at the rails and around the range edges.
  task automatic test_reset_settings;
    send_sticks(11'd0, 11'd0, 11'd0, 11'd0);
    send_sticks(11'd2047, 11'd2047, 11'd2047, 11'd2047);
    send_sticks(11'd989, 11'd989, 11'd989, 11'd989);
    send_sticks(11'd2011, 11'd2011, 11'd2011, 11'd2011);
    send_sticks(11'd988, 11'd2012, 11'd988, 11'd2012);
    send_sticks(11'd1500, 11'd1500, 11'd1500, 11'd1500);
    send_sticks(11'd2011, 11'd989, 11'd2011, 11'd989);
    send_sticks(11'd989, 11'd2011, 11'd1200, 11'd1800);
    send_sticks(11'd1, 11'd2046, 11'd1024, 11'd0);
  endtask

  // Full-range channels: saturation both ways, unused code, period and dead zone limits.
  task automatic test_level_extremes;
    apply_settings(0, 2047, 4095, 0, 8'h55, 8'h55, 8'h55, 8'h55, 1'b0);
    send_sticks(11'd2047, 11'd2047, 11'd2047, 11'd2047);
    send_sticks(11'd0, 11'd0, 11'd0, 11'd0);
    send_sticks(11'd1024, 11'd1023, 11'd1024, 11'd1023);
    apply_settings(0, 2047, 4095, 0, 8'hff, 8'hff, 8'h00, 8'h1b, 1'b0);
    send_sticks(11'd2047, 11'd2047, 11'd1500, 11'd0);
    apply_settings(0, 2047, 4095, 0, 8'haa, 8'haa, 8'haa, 8'haa, 1'b0);
    send_sticks(11'd2047, 11'd0, 11'd2047, 11'd0);
    apply_settings(0, 2047, 0, 0, 8'h55, 8'hff, 8'h00, 8'h00, 1'b0);
    send_sticks(11'd2047, 11'd0, 11'd700, 11'd300);
    apply_settings(0, 2047, 1, 0, 8'h55, 8'h00, 8'h00, 8'h00, 1'b0);
    send_sticks(11'd2047, 11'd1024, 11'd5, 11'd2040);
    // a single full-scale stick just clears the widest dead zone
    apply_settings(0, 2047, 4095, 32767, 8'h01, 8'h04, 8'h10, 8'hc0, 1'b0);
    send_sticks(11'd2047, 11'd0, 11'd2046, 11'd1);
  endtask

  // max not above min zeroes everything; a one-count span scales hard.
  task automatic test_channel_range;
    apply_settings(1000, 1000, 1000, 6554, 8'hdd, 8'h55, 8'h00, 8'h7d, 1'b0);
    send_sticks(11'd2047, 11'd0, 11'd2047, 11'd2047);
    send_sticks(11'd1000, 11'd1000, 11'd1000, 11'd1000);
    apply_settings(2047, 0, 4095, 0, 8'h55, 8'h55, 8'h55, 8'h55, 1'b0);
    send_sticks(11'd2047, 11'd2047, 11'd0, 11'd1024);
    apply_settings(2046, 2047, 4095, 0, 8'h5d, 8'hf1, 8'h37, 8'h9c, 1'b0);
    send_sticks(11'd2047, 11'd2046, 11'd2047, 11'd0);
    send_sticks(11'd0, 11'd2047, 11'd2046, 11'd2047);
  endtask

  task automatic test_random_mixing;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      randomize_settings();
      idle_en = (phase != RANDOM_PHASES / 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_sticks(pick_stick(), pick_stick(), pick_stick(), pick_stick());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_stick_aileron  = '0;
    in_stick_elevator = '0;
    in_stick_throttle = '0;
    in_stick_rudder   = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    idle_en           = 1'b1;
    error_count       = 0;
    requests_sent     = 0;
    results_checked   = 0;
    empty_range_requests = 0;
    saturated_requests   = 0;
    settings_applied     = 0;
    shadow_cfg.channel_min = RST_CHANNEL_MIN;
    shadow_cfg.channel_max = RST_CHANNEL_MAX;
    shadow_cfg.pwm_period  = RST_PWM_PERIOD;
    shadow_cfg.dead_zone   = RST_DEAD_ZONE;
    shadow_cfg.mix_rows[0] = RST_ROW_AILERON;
    shadow_cfg.mix_rows[1] = RST_ROW_ELEVATOR;
    shadow_cfg.mix_rows[2] = RST_ROW_THROTTLE;
    shadow_cfg.mix_rows[3] = RST_ROW_RUDDER;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_level_extremes();
    test_channel_range();
    test_random_mixing();

    drain_requests();
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_mix.size() != 0)
      report_mismatch($sformatf("%0d requests never produced a result", expected_mix.size()));

    $display("Covered %0d requests over %0d register settings:", requests_sent,
             settings_applied);
    $display("  %0d with an empty range, %0d saturating a motor.",
             empty_range_requests, saturated_requests);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("rc_channel_motor_mixer_core test passed");
    end else begin
      $display("rc_channel_motor_mixer_core test failed");
    end
    $finish;
  end

endmodule
